// ===== sv/tdl_pkg.sv =====
// ----------------------------------------------------------------------------
// tdl_pkg
// Shared types, constants and DFA functions for the table-driven lexer.
// ----------------------------------------------------------------------------
package tdl_pkg;

  localparam int MAX_TOKEN_LEN = 16;
  localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);
  localparam int IDX_W         = $clog2(MAX_TOKEN_LEN);

  // DFA states
  typedef logic [4:0] dfa_t;
  localparam dfa_t ST_START  = 5'd0;
  localparam dfa_t ST_ID     = 5'd1;
  localparam dfa_t ST_CONS   = 5'd3;
  localparam dfa_t ST_EQ     = 5'd5;
  localparam dfa_t ST_MINUS  = 5'd6;
  localparam dfa_t ST_MUL    = 5'd7;
  localparam dfa_t ST_LPAR   = 5'd8;
  localparam dfa_t ST_RPAR   = 5'd9;
  localparam dfa_t ST_LT     = 5'd10;
  localparam dfa_t ST_LE     = 5'd11;
  localparam dfa_t ST_NE     = 5'd12;
  localparam dfa_t ST_GT     = 5'd14;
  localparam dfa_t ST_GE     = 5'd15;
  localparam dfa_t ST_COLON  = 5'd17;
  localparam dfa_t ST_ASSIGN = 5'd18;
  localparam dfa_t ST_SEM    = 5'd20;
  localparam dfa_t ST_EOL    = 5'd21;

  // token types
  typedef logic [4:0] ttype_t;
  localparam ttype_t TT_ID     = 5'd0;
  localparam ttype_t TT_CONS   = 5'd1;
  localparam ttype_t TT_EQ     = 5'd2;
  localparam ttype_t TT_MINUS  = 5'd3;
  localparam ttype_t TT_MUL    = 5'd4;
  localparam ttype_t TT_LPAR   = 5'd5;
  localparam ttype_t TT_RPAR   = 5'd6;
  localparam ttype_t TT_LT     = 5'd7;
  localparam ttype_t TT_LE     = 5'd8;
  localparam ttype_t TT_NE     = 5'd9;
  localparam ttype_t TT_GT     = 5'd10;
  localparam ttype_t TT_GE     = 5'd11;
  localparam ttype_t TT_ASSIGN = 5'd12;
  localparam ttype_t TT_SEM    = 5'd13;
  localparam ttype_t TT_EOL    = 5'd14;
  localparam ttype_t TT_BEGIN  = 5'd15;  // first keyword, the rest follow densely

  // result kinds and error codes
  localparam logic       KIND_TOKEN = 1'b0;
  localparam logic       KIND_ERROR = 1'b1;
  localparam logic [1:0] ERR_SYMBOL = 2'd0;
  localparam logic [1:0] ERR_COLON  = 2'd1;
  localparam logic [1:0] ERR_LONG   = 2'd2;

  // keyword table, text right-justified in 8 bytes
  localparam int NUM_KW = 9;
  localparam int KW_MAX = 8;
  localparam logic [KW_MAX*8-1:0] KW_TEXT [NUM_KW] = '{
    "begin", "end", "integer", "if", "then", "else", "function", "read", "write"
  };
  localparam int KW_LEN [NUM_KW] = '{5, 3, 7, 2, 4, 4, 8, 4, 5};

  typedef enum logic [2:0] {
    EMIT_NONE  = 3'd0,
    EMIT_SYM   = 3'd1,
    EMIT_COLON = 3'd2,
    EMIT_LONG  = 3'd3,
    EMIT_CHAR  = 3'd4
  } emit_t;

  typedef struct packed {
    logic end_flag;
    logic can_move;
    logic at_start;
    logic at_colon;
    logic too_long;
    logic replay_last;
    logic out_free;
  } ctl_status_t;

  typedef struct packed {
    logic  capture;
    logic  step;
    logic  fin_begin;
    logic  idx_inc;
    logic  tok_clear;
    logic  line_reset;
    emit_t emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic ok;
    dfa_t ns;
  } dfa_move_t;

  function automatic dfa_move_t next_state(dfa_t s, logic [7:0] c);
    dfa_move_t m;
    m.ok = 1'b1;
    m.ns = ST_START;
    case (s)
      ST_START: begin
        case (c) inside
          ["a":"z"]: m.ns = ST_ID;
          ["0":"9"]: m.ns = ST_CONS;
          " ":       m.ns = ST_START;
          "=":       m.ns = ST_EQ;
          "-":       m.ns = ST_MINUS;
          "*":       m.ns = ST_MUL;
          "(":       m.ns = ST_LPAR;
          ")":       m.ns = ST_RPAR;
          "<":       m.ns = ST_LT;
          ">":       m.ns = ST_GT;
          ":":       m.ns = ST_COLON;
          ";":       m.ns = ST_SEM;
          8'h0A:     m.ns = ST_EOL;
          default:   m.ok = 1'b0;
        endcase
      end
      ST_ID: begin
        m.ns = ST_ID;
        m.ok = c inside {["a":"z"], ["0":"9"]};
      end
      ST_CONS: begin
        m.ns = ST_CONS;
        m.ok = c inside {["0":"9"]};
      end
      ST_LT: begin
        case (c)
          "=":     m.ns = ST_LE;
          ">":     m.ns = ST_NE;
          default: m.ok = 1'b0;
        endcase
      end
      ST_GT: begin
        m.ns = ST_GE;
        m.ok = (c == "=");
      end
      ST_COLON: begin
        m.ns = ST_ASSIGN;
        m.ok = (c == "=");
      end
      default: m.ok = 1'b0;
    endcase
    return m;
  endfunction

  function automatic ttype_t state_type(dfa_t s);
    ttype_t t;
    case (s)
      ST_CONS:   t = TT_CONS;
      ST_EQ:     t = TT_EQ;
      ST_MINUS:  t = TT_MINUS;
      ST_MUL:    t = TT_MUL;
      ST_LPAR:   t = TT_LPAR;
      ST_RPAR:   t = TT_RPAR;
      ST_LT:     t = TT_LT;
      ST_LE:     t = TT_LE;
      ST_NE:     t = TT_NE;
      ST_GT:     t = TT_GT;
      ST_GE:     t = TT_GE;
      ST_ASSIGN: t = TT_ASSIGN;
      ST_SEM:    t = TT_SEM;
      ST_EOL:    t = TT_EOL;
      default:   t = TT_ID;
    endcase
    return t;
  endfunction

  // character at position pos of keyword k, zero past its end
  function automatic logic [7:0] kw_char(int k, logic [LEN_W-1:0] pos);
    logic [7:0] ch;
    int         sh;
    ch = 8'h00;
    for (int j = 0; j < KW_MAX; j++) begin
      if (int'(pos) == j && j < KW_LEN[k]) begin
        sh = 8 * (KW_LEN[k] - 1 - j);
        ch = KW_TEXT[k][sh +: 8];
      end
    end
    return ch;
  endfunction

endpackage

// ===== sv/tdl_in_if.sv =====
// ----------------------------------------------------------------------------
// tdl_in_if
// Character channel: one source byte or end-of-text mark per word.
// ----------------------------------------------------------------------------
interface tdl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_text;

  modport source (output valid, output in_char, output end_of_text, input ready);
  modport sink (input valid, input in_char, input end_of_text, output ready);
endinterface

// ===== sv/tdl_out_if.sv =====
// ----------------------------------------------------------------------------
// tdl_out_if
// Result channel: one token character or error report per word.
// ----------------------------------------------------------------------------
interface tdl_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [4:0]  token_type;
  logic [1:0]  error_code;
  logic [7:0]  out_char;
  logic [15:0] line_number;
  logic        last;

  modport source (output valid, output kind, output token_type, output error_code,
                  output out_char, output line_number, output last, input ready);
  modport sink (input valid, input kind, input token_type, input error_code,
                input out_char, input line_number, input last, output ready);
endinterface

// ===== sv/table_driven_lexer_core.sv =====
// ----------------------------------------------------------------------------
// table_driven_lexer_core
// Fixed-DFA lexer with keyword table: source bytes in, token characters out.
// ----------------------------------------------------------------------------
// Each input word is one source byte (or an end-of-text mark). Identifiers,
// constants and the symbols = - * ( ) < <= <> > >= := ; and newline are
// recognized; spaces are skipped. When a byte cannot extend the pending token,
// the token goes out as a run of words, one per text character, each tagged
// with its type and line, last set on the final one; identifiers spelling a
// keyword get the keyword type, and a newline reads "EOL" and carries the
// advanced line. Errors (unknown byte, ':' not followed by '=', token of
// MAX_TOKEN_LEN or more characters) are single words with last set.
// A byte that extends a token or is skipped is captured, then evaluated by
// the DFA before the next byte is accepted. A byte that closes a token first
// starts a replay that walks the text buffer one character per cycle, while
// the output is free, through the single output register; then the
// byte is evaluated again from the start state. An unknown byte or a ':'
// without '=' is reported from the evaluation state with no replay; a token
// that is too long goes out as one word from the replay state. End of text
// in the start state or after a lone ':' (reported as an error) ends there,
// and otherwise the pending token is replayed first.
// Output back-pressure stalls the replay; a new byte is taken while the last
// result still waits in the output register.
// ----------------------------------------------------------------------------
module table_driven_lexer_core import tdl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  tdl_in_if.sink    chars,
  tdl_out_if.source tokens
);

  ctl_status_t status;   // datapath -> controller
  ctl_cmd_t    cmd;      // controller -> datapath
  logic        in_ready;

  // controller: owns the input handshake and sequences every word
  tdl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chars.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  assign chars.ready = in_ready;

  // datapath: DFA state, text buffer, keyword match, line count, result register
  tdl_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_char     (chars.in_char),
    .end_of_text (chars.end_of_text),
    .cmd         (cmd),
    .status      (status),
    .tokens      (tokens)
  );

endmodule

// ===== sv/tdl_datapath.sv =====
// ----------------------------------------------------------------------------
// tdl_datapath
// DFA state, token text buffer, keyword match, line count and result register.
// ----------------------------------------------------------------------------
module tdl_datapath import tdl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  in_char,
  input  logic        end_of_text,
  input  ctl_cmd_t    cmd,
  output ctl_status_t status,
  tdl_out_if.source   tokens
);

  logic [7:0]        c_reg;
  logic              end_reg;
  dfa_t              dstate;
  logic [LEN_W-1:0]  len;
  logic [15:0]       line;
  logic [NUM_KW-1:0] match;
  logic [NUM_KW-1:0] match_next;
  logic [IDX_W-1:0]  idx;
  logic [7:0]        text_buf [MAX_TOKEN_LEN];

  logic              out_valid;
  logic              out_kind;
  ttype_t            out_type;
  logic [1:0]        out_code;
  logic [7:0]        out_chr;
  logic [15:0]       out_line;
  logic              out_last;

  dfa_move_t         mv;
  logic [LEN_W-1:0]  eff_len;
  logic              too_long;
  logic              replay_last;
  logic              kw_hit;
  ttype_t            tok_type;
  logic [7:0]        rep_char;
  logic [7:0]        first_char;

  function automatic logic [7:0] eol_char(logic [LEN_W-1:0] pos);
    logic [7:0] ch;
    if (pos == LEN_W'(0)) begin
      ch = "E";
    end else if (pos == LEN_W'(1)) begin
      ch = "O";
    end else begin
      ch = "L";
    end
    return ch;
  endfunction

  always_comb begin
    mv          = next_state(dstate, c_reg);
    eff_len     = (dstate == ST_EOL) ? LEN_W'(3) : len;
    too_long    = eff_len >= LEN_W'(MAX_TOKEN_LEN);
    replay_last = (LEN_W'(idx) + LEN_W'(1)) == eff_len;
    rep_char    = (dstate == ST_EOL) ? eol_char(LEN_W'(idx)) : text_buf[idx];
    first_char  = (dstate == ST_EOL) ? 8'("E") : text_buf[0];
  end

  // keyword tracking: narrowed one character at a time as the text grows
  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      match_next[k] = match[k] && (int'(len) < KW_LEN[k]) && (c_reg == kw_char(k, len));
    end
  end

  always_comb begin
    kw_hit   = 1'b0;
    tok_type = state_type(dstate);
    for (int k = 0; k < NUM_KW; k++) begin
      if (!kw_hit && dstate == ST_ID && len < LEN_W'(MAX_TOKEN_LEN) && match[k] &&
          int'(len) == KW_LEN[k]) begin
        kw_hit   = 1'b1;
        tok_type = TT_BEGIN + 5'(k);
      end
    end
  end

  always_comb begin
    status.end_flag    = end_reg;
    status.can_move    = mv.ok;
    status.at_start    = (dstate == ST_START);
    status.at_colon    = (dstate == ST_COLON);
    status.too_long    = too_long;
    status.replay_last = replay_last;
    status.out_free    = !out_valid || tokens.ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      c_reg   <= in_char;
      end_reg <= end_of_text;
    end
    if (cmd.step && c_reg != " " && len < LEN_W'(MAX_TOKEN_LEN)) begin
      text_buf[len[IDX_W-1:0]] <= c_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate    <= ST_START;
      len       <= '0;
      line      <= 16'd1;
      match     <= '1;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.step) begin
        dstate <= mv.ns;
        if (c_reg != " ") begin
          match <= match_next;
          if (len < LEN_W'(MAX_TOKEN_LEN)) begin
            len <= len + LEN_W'(1);
          end
        end
      end
      if (cmd.tok_clear) begin
        dstate <= ST_START;
        len    <= '0;
        match  <= '1;
      end
      // newline advances the line before its run goes out
      if (cmd.fin_begin) begin
        idx <= '0;
        if (dstate == ST_EOL && line != 16'hFFFF) begin
          line <= line + 16'd1;
        end
      end
      if (cmd.idx_inc) begin
        idx <= idx + IDX_W'(1);
      end
      if (cmd.line_reset) begin
        line <= 16'd1;
      end
      if (cmd.emit != EMIT_NONE) begin
        out_valid <= 1'b1;
      end else if (tokens.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_line <= (cmd.emit != EMIT_NONE) ? line : out_line;
    case (cmd.emit)
      EMIT_SYM: begin
        out_kind <= KIND_ERROR;
        out_type <= TT_ID;
        out_code <= ERR_SYMBOL;
        out_chr  <= c_reg;
        out_last <= 1'b1;
      end
      EMIT_COLON: begin
        out_kind <= KIND_ERROR;
        out_type <= TT_ID;
        out_code <= ERR_COLON;
        out_chr  <= end_reg ? 8'h00 : c_reg;
        out_last <= 1'b1;
      end
      EMIT_LONG: begin
        out_kind <= KIND_ERROR;
        out_type <= TT_ID;
        out_code <= ERR_LONG;
        out_chr  <= first_char;
        out_last <= 1'b1;
      end
      EMIT_CHAR: begin
        out_kind <= KIND_TOKEN;
        out_type <= tok_type;
        out_code <= ERR_SYMBOL;
        out_chr  <= rep_char;
        out_last <= replay_last;
      end
      default: begin
      end
    endcase
  end

  assign tokens.valid       = out_valid;
  assign tokens.kind        = out_kind;
  assign tokens.token_type  = out_type;
  assign tokens.error_code  = out_code;
  assign tokens.out_char    = out_chr;
  assign tokens.line_number = out_line;
  assign tokens.last        = out_last;

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(MAX_TOKEN_LEN))
    else $error("token length past buffer depth");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    line != 16'd0)
    else $error("line count wrapped to zero");

  a_start_empty: assert property (@(posedge clk) disable iff (rst)
    dstate == ST_START |-> len == '0)
    else $error("text pending in start state");

endmodule

// ===== sv/tdl_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdl_ctrl
// Sequencer: takes a word, steps the DFA, settles and replays finished tokens.
// ----------------------------------------------------------------------------
module tdl_ctrl import tdl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ctl_status_t status,
  output ctl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EVAL   = 3'b010,
    S_REPLAY = 3'b100
  } fsm_t;

  fsm_t fsm;
  fsm_t fsm_next;

  assign in_ready = (fsm == S_IDLE);

  always_comb begin
    fsm_next       = fsm;
    cmd.capture    = 1'b0;
    cmd.step       = 1'b0;
    cmd.fin_begin  = 1'b0;
    cmd.idx_inc    = 1'b0;
    cmd.tok_clear  = 1'b0;
    cmd.line_reset = 1'b0;
    cmd.emit       = EMIT_NONE;
    case (fsm)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          fsm_next    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (status.end_flag) begin
          if (status.at_start) begin
            cmd.tok_clear  = 1'b1;
            cmd.line_reset = 1'b1;
            fsm_next       = S_IDLE;
          end else if (status.at_colon) begin
            if (status.out_free) begin
              cmd.emit       = EMIT_COLON;
              cmd.tok_clear  = 1'b1;
              cmd.line_reset = 1'b1;
              fsm_next       = S_IDLE;
            end
          end else begin
            cmd.fin_begin = 1'b1;
            fsm_next      = S_REPLAY;
          end
        end else if (status.can_move) begin
          cmd.step = 1'b1;
          fsm_next = S_IDLE;
        end else if (status.at_start) begin
          if (status.out_free) begin
            cmd.emit = EMIT_SYM;
            fsm_next = S_IDLE;
          end
        end else if (status.at_colon) begin
          // byte after a lone colon is reported and dropped
          if (status.out_free) begin
            cmd.emit      = EMIT_COLON;
            cmd.tok_clear = 1'b1;
            fsm_next      = S_IDLE;
          end
        end else begin
          cmd.fin_begin = 1'b1;
          fsm_next      = S_REPLAY;
        end
      end
      S_REPLAY: begin
        if (status.out_free) begin
          if (status.too_long || status.replay_last) begin
            cmd.emit      = status.too_long ? EMIT_LONG : EMIT_CHAR;
            cmd.tok_clear = 1'b1;
            if (status.end_flag) begin
              cmd.line_reset = 1'b1;
              fsm_next       = S_IDLE;
            end else begin
              // the closing byte runs again from the start state
              fsm_next = S_EVAL;
            end
          end else begin
            cmd.emit    = EMIT_CHAR;
            cmd.idx_inc = 1'b1;
          end
        end
      end
      default: begin
        fsm_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm <= S_IDLE;
    end else begin
      fsm <= fsm_next;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit != EMIT_NONE |-> status.out_free)
    else $error("result loaded into a full output register");

  a_capture_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> fsm == S_EVAL)
    else $error("captured word not evaluated");

  a_step_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (cmd.emit == EMIT_NONE && !cmd.tok_clear && !cmd.fin_begin))
    else $error("DFA step overlaps token settle");

endmodule

// ===== bench/table_driven_lexer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_driven_lexer_core_tb
// Self-checking bench: source bytes go in, every token or error word coming
// out is checked field by field against a lexer model or a typed row's word.
// ----------------------------------------------------------------------------
module table_driven_lexer_core_tb;
  import tdl_pkg::*;

  localparam int QUIET_LIMIT  = 1000;   // cycles with no word moving on either side
  localparam int TAIL_CYCLES  = 40;     // longest replay is well under this
  localparam int RANDOM_ITEMS = 320;
  localparam int MODE_CHUNK   = 40;     // random items per idling mode
  localparam int NL_BURST     = 8;      // newlines sent back to back
  localparam int LINE_MAX     = 65535;
  localparam int DIR_ROWS     = 26;
  localparam logic [7:0] CH_NL = 8'h0A;

  // one result word, field order as on the port
  typedef struct packed {
    logic        kind;
    ttype_t      ttype;
    logic [1:0]  ecode;
    logic [7:0]  ch;
    logic [15:0] line;
    logic        last;
  } word_t;

  typedef struct packed {
    logic [7:0] c;
    logic       eot;
  } src_t;

  // directed row: typed rows carry their single expected word, the rest
  // take whatever the lexer model predicts
  typedef struct {
    src_t  src;
    logic  typed;
    word_t want;
  } row_t;

  localparam word_t NO_WORD     = '0;
  localparam word_t W_SYM_00    = '{KIND_ERROR, '0, ERR_SYMBOL, 8'h00, 16'd1, 1'b1};
  localparam word_t W_SYM_FF    = '{KIND_ERROR, '0, ERR_SYMBOL, 8'hFF, 16'd1, 1'b1};
  localparam word_t W_COLON_X   = '{KIND_ERROR, '0, ERR_COLON, "x", 16'd1, 1'b1};
  localparam word_t W_COLON_EOT = '{KIND_ERROR, '0, ERR_COLON, 8'h00, 16'd2, 1'b1};

  // Directed walk: extreme bytes right after reset, broken colon, a keyword,
  // the symbol tokens <>, ;, >=, :=, (, ), *, - and =, a newline that bumps the line,
  // a colon cut off by end of text, and end of text in the start state (no word at all).
  row_t dir_rows [DIR_ROWS] = '{
    '{'{8'h00, 1'b0}, 1'b1, W_SYM_00},
    '{'{8'hFF, 1'b0}, 1'b1, W_SYM_FF},
    '{'{":",   1'b0}, 1'b0, NO_WORD},
    '{'{"x",   1'b0}, 1'b1, W_COLON_X},
    '{'{"i",   1'b0}, 1'b0, NO_WORD},
    '{'{"f",   1'b0}, 1'b0, NO_WORD},
    '{'{" ",   1'b0}, 1'b0, NO_WORD},
    '{'{"<",   1'b0}, 1'b0, NO_WORD},
    '{'{">",   1'b0}, 1'b0, NO_WORD},
    '{'{"9",   1'b0}, 1'b0, NO_WORD},
    '{'{"0",   1'b0}, 1'b0, NO_WORD},
    '{'{";",   1'b0}, 1'b0, NO_WORD},
    '{'{CH_NL, 1'b0}, 1'b0, NO_WORD},
    '{'{">",   1'b0}, 1'b0, NO_WORD},
    '{'{"=",   1'b0}, 1'b0, NO_WORD},
    '{'{":",   1'b0}, 1'b0, NO_WORD},
    '{'{"=",   1'b0}, 1'b0, NO_WORD},
    '{'{"(",   1'b0}, 1'b0, NO_WORD},
    '{'{")",   1'b0}, 1'b0, NO_WORD},
    '{'{"*",   1'b0}, 1'b0, NO_WORD},
    '{'{"-",   1'b0}, 1'b0, NO_WORD},
    '{'{"=",   1'b0}, 1'b0, NO_WORD},
    '{'{"z",   1'b0}, 1'b0, NO_WORD},
    '{'{":",   1'b0}, 1'b0, NO_WORD},
    '{'{8'h00, 1'b1}, 1'b1, W_COLON_EOT},
    '{'{8'hFF, 1'b1}, 1'b0, NO_WORD}
  };

  string kw_words [NUM_KW] = '{
    "begin", "end", "integer", "if", "then", "else", "function", "read", "write"
  };
  string sym_words [12] = '{
    "=", "-", "*", "(", ")", "<", "<=", "<>", ">", ">=", ":=", ";"
  };

  logic clk = 1'b0;
  logic rst;

  tdl_in_if  chars ();
  tdl_out_if tokens ();

  table_driven_lexer_core u_top (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars),
    .tokens (tokens)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // lexer model state
  dfa_t       lx_state;
  logic [7:0] lx_text [MAX_TOKEN_LEN];
  int         lx_len;
  int         lx_line;
  word_t      step_words [$];   // words caused by the byte just taken

  word_t token_q [$];           // words still owed by the block
  src_t  src_q [$];
  logic  in_idle;
  logic  out_idle;
  int    out_stall;
  int    fail_count;
  int    quiet_cycles;
  word_t got_word;

  // -------------------------------------------------------------------------
  // Lexer model
  // -------------------------------------------------------------------------
  function automatic logic lex_move(input dfa_t s, input logic [7:0] c, output dfa_t ns);
    logic dig;
    logic alpha;
    logic ok;
    dig   = (c >= "0") && (c <= "9");
    alpha = (c >= "a") && (c <= "z");
    ns    = ST_START;
    ok    = 1'b1;
    case (s)
      ST_START: begin
        if (alpha) ns = ST_ID;
        else if (dig) ns = ST_CONS;
        else begin
          case (c)
            " ":     ns = ST_START;
            "=":     ns = ST_EQ;
            "-":     ns = ST_MINUS;
            "*":     ns = ST_MUL;
            "(":     ns = ST_LPAR;
            ")":     ns = ST_RPAR;
            "<":     ns = ST_LT;
            ">":     ns = ST_GT;
            ":":     ns = ST_COLON;
            ";":     ns = ST_SEM;
            CH_NL:   ns = ST_EOL;
            default: ok = 1'b0;
          endcase
        end
      end
      ST_ID: begin
        ns = ST_ID;
        ok = alpha || dig;
      end
      ST_CONS: begin
        ns = ST_CONS;
        ok = dig;
      end
      ST_LT: begin
        if (c == "=") ns = ST_LE;
        else if (c == ">") ns = ST_NE;
        else ok = 1'b0;
      end
      ST_GT: begin
        ns = ST_GE;
        ok = (c == "=");
      end
      ST_COLON: begin
        ns = ST_ASSIGN;
        ok = (c == "=");
      end
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // token type of an accepting state, -1 where the state accepts nothing
  function automatic int lex_type(input dfa_t s);
    case (s)
      ST_ID:     return TT_ID;
      ST_CONS:   return TT_CONS;
      ST_EQ:     return TT_EQ;
      ST_MINUS:  return TT_MINUS;
      ST_MUL:    return TT_MUL;
      ST_LPAR:   return TT_LPAR;
      ST_RPAR:   return TT_RPAR;
      ST_LT:     return TT_LT;
      ST_LE:     return TT_LE;
      ST_NE:     return TT_NE;
      ST_GT:     return TT_GT;
      ST_GE:     return TT_GE;
      ST_ASSIGN: return TT_ASSIGN;
      ST_SEM:    return TT_SEM;
      ST_EOL:    return TT_EOL;
      default:   return -1;
    endcase
  endfunction

  function automatic void note_word(input logic kind, input ttype_t t, input logic [1:0] e,
                                    input logic [7:0] ch, input logic last);
    step_words.push_back(word_t'{kind, t, e, ch, lx_line[15:0], last});
  endfunction

  // close the pending token; dropped says the current byte is used up
  function automatic void lex_finish(input logic [7:0] ch, output logic dropped);
    int         t;
    int         n;
    logic [7:0] txt [MAX_TOKEN_LEN];
    logic       hit;
    t       = lex_type(lx_state);
    dropped = 1'b0;
    if (t < 0) begin
      note_word(KIND_ERROR, '0, (lx_state == ST_COLON) ? ERR_COLON : ERR_SYMBOL, ch, 1'b1);
      dropped = 1'b1;
    end else begin
      txt = lx_text;
      n   = lx_len;
      if (lx_state == ST_ID && n < MAX_TOKEN_LEN) begin
        for (int k = 0; k < NUM_KW; k++) begin
          if (n == kw_words[k].len()) begin
            hit = 1'b1;
            for (int i = 0; i < n; i++)
              if (txt[i] != kw_words[k][i]) hit = 1'b0;
            if (hit) begin
              t = TT_BEGIN + k;
              break;
            end
          end
        end
      end
      // newline reads as EOL and already carries the next line
      if (lx_state == ST_EOL) begin
        n      = 3;
        txt[0] = "E";
        txt[1] = "O";
        txt[2] = "L";
        if (lx_line < LINE_MAX) lx_line++;
      end
      if (n < MAX_TOKEN_LEN) begin
        for (int i = 0; i < n; i++)
          note_word(KIND_TOKEN, ttype_t'(t), '0, txt[i], i == n - 1);
      end else begin
        note_word(KIND_ERROR, '0, ERR_LONG, txt[0], 1'b1);
      end
    end
    lx_state = ST_START;
    lx_len   = 0;
  endfunction

  function automatic void lex_step(input logic [7:0] c, input logic eot);
    logic dropped;
    dfa_t ns;
    step_words.delete();
    dropped = 1'b0;
    if (eot) begin
      if (lx_state != ST_START) lex_finish(8'h00, dropped);
      lx_state = ST_START;
      lx_len   = 0;
      lx_line  = 1;
    end else begin
      // a byte that cannot extend the token closes it and is run again
      while (!dropped) begin
        if (lex_move(lx_state, c, ns)) begin
          if (c != " " && lx_len < MAX_TOKEN_LEN) begin
            lx_text[lx_len] = c;
            lx_len++;
          end
          lx_state = ns;
          break;
        end
        lex_finish(c, dropped);
      end
    end
  endfunction

  // -------------------------------------------------------------------------
  // Random source text
  // -------------------------------------------------------------------------
  function automatic void add_byte(input logic [7:0] c, input logic eot);
    src_q.push_back(src_t'{c, eot});
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], 1'b0);
  endfunction

  function automatic logic [7:0] rand_letter();
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  // mostly well-formed text: identifiers, keywords, constants, symbols and
  // newlines, with some noise bytes, broken colons and end-of-text marks
  function automatic void build_source(input int target);
    int pick;
    int n;
    while (src_q.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        // identifier, now and then long enough to overflow the buffer
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
        add_byte(rand_letter(), 1'b0);
        for (int i = 1; i < n; i++)
          add_byte(($urandom_range(0, 2) == 0) ? rand_digit() : rand_letter(), 1'b0);
      end else if (pick < 34) begin
        add_text(kw_words[$urandom_range(0, NUM_KW - 1)]);
        if ($urandom_range(0, 3) == 0) add_byte(rand_letter(), 1'b0);
      end else if (pick < 44) begin
        n = ($urandom_range(0, 14) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 5);
        for (int i = 0; i < n; i++) add_byte(rand_digit(), 1'b0);
      end else if (pick < 68) begin
        add_text(sym_words[$urandom_range(0, 11)]);
      end else if (pick < 76) begin
        add_byte(CH_NL, 1'b0);
      end else if (pick < 82) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) add_byte(" ", 1'b0);
      end else if (pick < 88) begin
        add_byte(":", 1'b0);
        add_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 96) begin
        add_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        add_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      if ($urandom_range(0, 1) == 0) add_byte(" ", 1'b0);
    end
  endfunction

  // -------------------------------------------------------------------------
  // Source side: one word per call, model updated at the accepting edge
  // -------------------------------------------------------------------------
  task automatic send_src(input src_t s, input logic typed, input word_t want);
    int gap;
    gap = in_idle ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      chars.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    chars.valid       <= 1'b1;
    chars.in_char     <= s.c;
    chars.end_of_text <= s.eot;
    do @(posedge clk); while (chars.ready !== 1'b1);
    lex_step(s.c, s.eot);
    if (typed) begin
      token_q.push_back(want);
    end else begin
      foreach (step_words[i]) token_q.push_back(step_words[i]);
    end
  endtask

  function automatic string fmt_word(input word_t w);
    return $sformatf("kind=%0d type=%0d err=%0d char=%02h line=%0d last=%0d",
                     w.kind, w.ttype, w.ecode, w.ch, w.line, w.last);
  endfunction

  // -------------------------------------------------------------------------
  // Result side: random back-pressure and the checker
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    if (out_stall > 0) begin
      tokens.ready <= 1'b0;
      out_stall--;
    end else begin
      tokens.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && tokens.valid === 1'b1 && tokens.ready === 1'b1) begin
      got_word = word_t'{tokens.kind, tokens.token_type, tokens.error_code,
                         tokens.out_char, tokens.line_number, tokens.last};
      if (token_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected word, expected none, got %s", $time, fmt_word(got_word));
      end else begin
        if (got_word !== token_q[0]) begin
          fail_count++;
          $display("%0t: word mismatch, expected %s, got %s", $time,
                   fmt_word(token_q[0]), fmt_word(got_word));
        end
        void'(token_q.pop_front());
      end
      out_stall = out_idle ? $urandom_range(0, 11) : 0;
    end
  end

  // watchdog: a run that stops moving words in either direction is dead
  always @(posedge clk) begin
    if (rst || (chars.valid === 1'b1 && chars.ready === 1'b1) ||
        (tokens.valid === 1'b1 && tokens.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("FAIL table_driven_lexer_core");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    rst               = 1'b1;
    chars.valid       = 1'b0;
    chars.in_char     = 8'h00;
    chars.end_of_text = 1'b0;
    tokens.ready      = 1'b0;
    out_stall         = 0;
    fail_count        = 0;
    quiet_cycles      = 0;
    in_idle           = 1'b1;
    out_idle          = 1'b1;
    lx_state          = ST_START;
    lx_len            = 0;
    lx_line           = 1;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_src(dir_rows[i].src, dir_rows[i].typed, dir_rows[i].want);

    // random text; idling switches per chunk so both busy and quiet stretches occur
    build_source(RANDOM_ITEMS);
    foreach (src_q[i]) begin
      if (i % MODE_CHUNK == 0) begin
        in_idle  = ($urandom_range(0, 3) != 0);
        out_idle = ($urandom_range(0, 3) != 0);
      end
      send_src(src_q[i], 1'b0, NO_WORD);
    end

    // a burst of newlines at full speed, then a token, an error, a newline and
    // a token, end of text to restart the line count, a keyword and end of text
    in_idle  = 1'b0;
    out_idle = 1'b0;
    src_q.delete();
    for (int i = 0; i < NL_BURST; i++) add_byte(CH_NL, 1'b0);
    add_text("a1");
    add_byte(8'h80, 1'b0);
    add_byte(CH_NL, 1'b0);
    add_byte("b", 1'b0);
    add_byte(8'h00, 1'b1);
    add_text("end");
    add_byte(8'h55, 1'b1);
    foreach (src_q[i]) send_src(src_q[i], 1'b0, NO_WORD);

    @(negedge clk);
    chars.valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS table_driven_lexer_core");
    end else begin
      $display("FAIL table_driven_lexer_core");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tdl_pkg.sv
sv/tdl_in_if.sv
sv/tdl_out_if.sv
sv/tdl_datapath.sv
sv/tdl_ctrl.sv
sv/table_driven_lexer_core.sv
bench/table_driven_lexer_core_tb.sv
